>>> src/tpag_pkg.sv
`timescale 1ns / 1ps

package tpag_pkg;

	localparam int MAX_RANK   = 4;
	localparam int DIM_BITS   = 16;
	localparam int POS_BITS   = 24;
	localparam int INDEX_BITS = 24;
	localparam int FILL_BITS  = 32;
	localparam int PACK_BITS  = MAX_RANK * DIM_BITS;
	localparam int REM_BITS   = DIM_BITS + 1;

	// Pipeline layout: one restoring division step per stage for each outer
	// dimension, then pad subtraction, one modulo step per stage, the reflect
	// fold, and one multiply-add per stage for the linear index.
	localparam int DIV_STEPS  = (MAX_RANK - 1) * POS_BITS;
	localparam int PAD_STAGE  = DIV_STEPS;
	localparam int MOD_FIRST  = PAD_STAGE + 1;
	localparam int MAP_STAGE  = MOD_FIRST + POS_BITS;
	localparam int MUL_FIRST  = MAP_STAGE + 1;
	localparam int NUM_STEPS  = MUL_FIRST + MAX_RANK - 1;

	localparam logic [1:0] MODE_CONSTANT = 2'd0;
	localparam logic [1:0] MODE_EDGE     = 2'd1;
	localparam logic [1:0] MODE_REFLECT  = 2'd2;

	localparam logic [2:0] REG_PAD_MODE  = 3'd0;
	localparam logic [2:0] REG_RANK      = 3'd1;
	localparam logic [2:0] REG_IN_SIZES  = 3'd2;
	localparam logic [2:0] REG_OUT_SIZES = 3'd3;
	localparam logic [2:0] REG_PAD_BEGIN = 3'd4;
	localparam logic [2:0] REG_FILL      = 3'd5;

	typedef struct packed {
		logic [1:0]           mode;
		logic [MAX_RANK-1:0]  used;
		logic [PACK_BITS-1:0] in_sz;
		logic [PACK_BITS-1:0] out_sz;
		logic [PACK_BITS-1:0] pad;
	} cfg_t;

	typedef struct packed {
		logic [DIM_BITS-1:0]                 rem;
		logic [POS_BITS-1:0]                 quo;
		logic [MAX_RANK-1:0][DIM_BITS-1:0]   crd;
		logic [MAX_RANK-1:0]                 neg;
		logic [MAX_RANK-1:0][POS_BITS-1:0]   mag;
		logic [MAX_RANK-1:0][REM_BITS-1:0]   mrem;
		logic                                fill;
		logic [INDEX_BITS-1:0]               idx;
	} item_t;

	function automatic logic [DIM_BITS-1:0] dim_of(logic [PACK_BITS-1:0] p, int d);
		return p[(MAX_RANK - 1 - d) * DIM_BITS +: DIM_BITS];
	endfunction

	function automatic logic [REM_BITS-1:0] period_of(logic [DIM_BITS-1:0] isz);
		logic [REM_BITS-1:0] per;
		if (isz > DIM_BITS'(1))
			per = {isz - DIM_BITS'(1), 1'b0};
		else
			per = REM_BITS'(1);
		return per;
	endfunction

	function automatic item_t item_init(logic [POS_BITS-1:0] pos);
		item_t y;
		y = '0;
		y.quo = pos;
		return y;
	endfunction

	// One restoring division step; a divisor of one passes the value through
	// for unused dimensions and zero output sizes.
	function automatic item_t div_step(item_t x, cfg_t cf, int d, logic first, logic last);
		item_t               y;
		logic [DIM_BITS-1:0] osz;
		logic [DIM_BITS-1:0] dv;
		logic [DIM_BITS-1:0] r0;
		logic [REM_BITS-1:0] t;
		y   = x;
		osz = dim_of(cf.out_sz, d);
		dv  = (cf.used[d] && osz != '0) ? osz : DIM_BITS'(1);
		r0  = first ? '0 : x.rem;
		t   = {r0, x.quo[POS_BITS-1]};
		y.quo = {x.quo[POS_BITS-2:0], 1'b0};
		if (t >= {1'b0, dv}) begin
			y.rem    = DIM_BITS'(t - {1'b0, dv});
			y.quo[0] = 1'b1;
		end else begin
			y.rem = t[DIM_BITS-1:0];
		end
		if (last)
			y.crd[d] = y.rem;
		return y;
	endfunction

	function automatic item_t pad_step(item_t x, cfg_t cf);
		item_t               y;
		logic [POS_BITS-1:0] coord;
		logic [POS_BITS:0]   diff;
		logic [POS_BITS-1:0] mag;
		logic [DIM_BITS-1:0] isz;
		logic                neg;
		logic                oob;
		y = x;
		for (int d = 0; d < MAX_RANK; d++) begin
			coord = (d == 0) ? x.quo : POS_BITS'(x.crd[d]);
			isz   = dim_of(cf.in_sz, d);
			diff  = {1'b0, coord} - (POS_BITS + 1)'(dim_of(cf.pad, d));
			neg   = diff[POS_BITS];
			mag   = neg ? POS_BITS'(-diff) : diff[POS_BITS-1:0];
			oob   = neg || (mag >= POS_BITS'(isz));
			y.neg[d]  = neg;
			y.mag[d]  = mag;
			y.mrem[d] = '0;
			if (cf.mode == MODE_EDGE) begin
				if (neg || isz == '0)
					y.crd[d] = '0;
				else if (mag >= POS_BITS'(isz))
					y.crd[d] = isz - DIM_BITS'(1);
				else
					y.crd[d] = mag[DIM_BITS-1:0];
			end else begin
				y.crd[d] = mag[DIM_BITS-1:0];
				if (cf.mode != MODE_REFLECT && cf.used[d] && oob)
					y.fill = 1'b1;
			end
		end
		return y;
	endfunction

	function automatic item_t mod_step(item_t x, cfg_t cf);
		item_t               y;
		logic [REM_BITS-1:0] per;
		logic [REM_BITS:0]   t;
		y = x;
		for (int d = 0; d < MAX_RANK; d++) begin
			per      = period_of(dim_of(cf.in_sz, d));
			t        = {x.mrem[d], x.mag[d][POS_BITS-1]};
			y.mag[d] = {x.mag[d][POS_BITS-2:0], 1'b0};
			if (t >= {1'b0, per})
				y.mrem[d] = REM_BITS'(t - {1'b0, per});
			else
				y.mrem[d] = t[REM_BITS-1:0];
		end
		return y;
	endfunction

	function automatic item_t map_step(item_t x, cfg_t cf);
		item_t               y;
		logic [DIM_BITS-1:0] isz;
		logic [REM_BITS-1:0] per;
		logic [REM_BITS-1:0] m;
		y = x;
		for (int d = 0; d < MAX_RANK; d++) begin
			isz = dim_of(cf.in_sz, d);
			per = period_of(isz);
			m   = (x.neg[d] && x.mrem[d] != '0) ? per - x.mrem[d] : x.mrem[d];
			if (cf.mode == MODE_REFLECT) begin
				if (isz > DIM_BITS'(1))
					y.crd[d] = (m < {1'b0, isz}) ? m[DIM_BITS-1:0] : DIM_BITS'(per - m);
				else
					y.crd[d] = '0;
			end
			if (!cf.used[d])
				y.crd[d] = '0;
		end
		y.idx = INDEX_BITS'(y.crd[0]);
		return y;
	endfunction

	function automatic item_t mul_step(item_t x, cfg_t cf, int d);
		item_t                          y;
		logic [DIM_BITS-1:0]            f;
		logic [INDEX_BITS+DIM_BITS-1:0] prod;
		y     = x;
		f     = cf.used[d] ? dim_of(cf.in_sz, d) : DIM_BITS'(1);
		prod  = x.idx * f;
		y.idx = prod[INDEX_BITS-1:0] + INDEX_BITS'(x.crd[d]);
		return y;
	endfunction

endpackage

>>> src/tensor_pad_address_generator.sv
`timescale 1ns / 1ps
// Pipeline: the entry register loads at the input transfer, then 72 division steps, pad
// subtraction, 24 modulo steps, the reflect fold and 3 multiply-adds each end in a register.
// Throughput: one item per cycle; the pipeline advances as a whole whenever the
// output register is empty or its result is being taken, so a stall freezes every stage.
// Reset: arst_n clears all valid bits and sets the registers to their defaults
// (constant mode, rank 1, all sizes, pads and the fill value zero).

module tensor_pad_address_generator (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [2:0]                           cfg_index,
	input  logic [tpag_pkg::PACK_BITS-1:0]       cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [tpag_pkg::POS_BITS-1:0]        out_position,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [tpag_pkg::POS_BITS-1:0]        source_index,
	output logic                                 use_fill,
	output logic [tpag_pkg::FILL_BITS-1:0]       fill_bits
);

	localparam int NREG = tpag_pkg::NUM_STEPS + 1;

	// Configuration registers. The user must change them only while the pipeline is empty;
	// the block itself does not enforce this, and every stage reads them directly.
	logic [1:0]                        pad_mode_q;
	logic [2:0]                        rank_q;
	logic [tpag_pkg::PACK_BITS-1:0]    in_sizes_q;
	logic [tpag_pkg::PACK_BITS-1:0]    out_sizes_q;
	logic [tpag_pkg::PACK_BITS-1:0]    pad_begin_q;
	logic [tpag_pkg::FILL_BITS-1:0]    fill_value_q;

	tpag_pkg::cfg_t                    cfg;
	logic [tpag_pkg::MAX_RANK-1:0]     used;
	logic                              adv;

	tpag_pkg::item_t                   item_s [NREG];
	logic [NREG-1:0]                   vld_s;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pad_mode_q   <= tpag_pkg::MODE_CONSTANT;
			rank_q       <= 3'd1;
			in_sizes_q   <= '0;
			out_sizes_q  <= '0;
			pad_begin_q  <= '0;
			fill_value_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				tpag_pkg::REG_PAD_MODE:  pad_mode_q   <= cfg_data[1:0];
				tpag_pkg::REG_RANK:      rank_q       <= cfg_data[2:0];
				tpag_pkg::REG_IN_SIZES:  in_sizes_q   <= cfg_data;
				tpag_pkg::REG_OUT_SIZES: out_sizes_q  <= cfg_data;
				tpag_pkg::REG_PAD_BEGIN: pad_begin_q  <= cfg_data;
				tpag_pkg::REG_FILL:      fill_value_q <= cfg_data[tpag_pkg::FILL_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Rank zero behaves as one and anything above four as four.
	always_comb begin
		unique case (rank_q) inside
			3'd0, 3'd1: used = 4'b0001;
			3'd2:       used = 4'b0011;
			3'd3:       used = 4'b0111;
			default:    used = 4'b1111;
		endcase
	end

	assign cfg = '{mode: pad_mode_q, used: used, in_sz: in_sizes_q,
		out_sz: out_sizes_q, pad: pad_begin_q};

	// The whole pipeline moves together; a bubble in it is simply carried.
	assign adv      = !vld_s[NREG-1] || out_ready;
	assign in_ready = adv;

	always_ff @(posedge clk) begin
		if (adv)
			item_s[0] <= tpag_pkg::item_init(out_position);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[NREG-2:0], in_valid};
		end
	end

	for (genvar k = 0; k < tpag_pkg::NUM_STEPS; k++) begin : g_stage
		tpag_pkg::item_t nxt;

		if (k < tpag_pkg::DIV_STEPS) begin : g_div
			// Outer dimensions are peeled off innermost first.
			localparam int DIM  = tpag_pkg::MAX_RANK - 1 - k / tpag_pkg::POS_BITS;
			localparam int STEP = k % tpag_pkg::POS_BITS;
			assign nxt = tpag_pkg::div_step(item_s[k], cfg, DIM, STEP == 0,
				STEP == tpag_pkg::POS_BITS - 1);
		end else if (k == tpag_pkg::PAD_STAGE) begin : g_pad
			assign nxt = tpag_pkg::pad_step(item_s[k], cfg);
		end else if (k < tpag_pkg::MAP_STAGE) begin : g_mod
			assign nxt = tpag_pkg::mod_step(item_s[k], cfg);
		end else if (k == tpag_pkg::MAP_STAGE) begin : g_map
			assign nxt = tpag_pkg::map_step(item_s[k], cfg);
		end else begin : g_mul
			localparam int DIM = k - tpag_pkg::MAP_STAGE;
			assign nxt = tpag_pkg::mul_step(item_s[k], cfg, DIM);
		end

		always_ff @(posedge clk) begin
			if (adv)
				item_s[k+1] <= nxt;
		end
	end

	// A fill element reads nothing from the source tensor.
	assign out_valid    = vld_s[NREG-1];
	assign use_fill     = item_s[NREG-1].fill;
	assign source_index = item_s[NREG-1].fill ? '0 : item_s[NREG-1].idx;
	assign fill_bits    = item_s[NREG-1].fill ? fill_value_q : '0;

endmodule

>>> src/tpag_checker.sv
`timescale 1ns / 1ps

module tpag_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_ready,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic [tpag_pkg::POS_BITS-1:0]     source_index,
	input logic                              use_fill,
	input logic [tpag_pkg::FILL_BITS-1:0]    fill_bits
);

	// An empty output register never holds back the input.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

	a_fill_no_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && use_fill |-> source_index == '0)
		else $error("fill element carries a source index");

	a_no_fill_bits: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !use_fill |-> fill_bits == '0)
		else $error("fill bits on a gathered element");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(source_index) && $stable(use_fill))
		else $error("stalled result changed");

endmodule

bind tensor_pad_address_generator tpag_checker u_tpag_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.source_index (source_index),
	.use_fill     (use_fill),
	.fill_bits    (fill_bits)
);
